// ===== sv/spp_pkg.sv =====
package spp_pkg;

    localparam int NUM_STARS     = 1024;
    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 768;

    localparam int IDX_W   = 10;
    localparam int ADDR_W  = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;
    localparam int COORD_W = 10;
    localparam int DEPTH_W = 15;
    localparam int SPEED_W = 9;
    localparam int EYE_W   = 7;
    localparam int PIX_W   = 10;
    localparam int PADDR_W = 22;

    localparam logic [EYE_W-1:0]   EYE_RESET   = 7'd100;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 15'd25600;

    // Denominator D = 256*E + depth, and 2*D.
    localparam int DEN_W  = 16;
    localparam int TWOD_W = DEN_W + 1;
    // Signed numerator, and its positive remainder (below size * 2D).
    localparam int NUM_W  = 32;
    localparam int REM_W  = 30;
    localparam int MAX_SZ = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int QW     = $clog2(MAX_SZ);

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DEPTH_W-1:0] depth;
        logic [SPEED_W-1:0] speed;
    } t_star;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        t_star            star;
    } t_item;

    // An advanced star on its way to projection.
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DEPTH_W-1:0] depth;
    } t_adv;

    typedef struct packed {
        logic valid;
        logic vis;
    } t_tag;

endpackage

// ===== sv/starfield_perspective_projector_top.sv =====
// Starfield projector. A store of star records (x, y, depth, speed) lives in
// one on-chip memory. Items arrive on the s_axis channel: tuser carries the
// operation (load or advance), tdata the star index and the load fields.
// A load writes one record and produces no result. An advance lowers the
// star's depth by its speed (wrapping to 100.0 at zero or below), writes it
// back and produces one result item on m_axis: pixel column, row and frame
// buffer byte address in tdata, the visible flag in tuser. Invisible stars
// report zero coordinates.
// The eye distance register is written through i_cfg_we / i_cfg_wdata;
// the user must write it only while the block is idle, which the block
// does not enforce; it resets to 100. Throughput is one item per cycle
// while m_axis accepts. The memory is read when an item is accepted and
// written from the next register stage; a record written by the previous
// item is forwarded, so back-to-back items on the same star are exact.
// From acceptance an item passes the store access, the numerator and
// visibility math, the pipelined restoring divider (one quotient bit per
// stage) and the output register to m_axis_tvalid. A stall on m_axis
// freezes the whole pipeline and drops s_axis_tready; while the output
// register is empty, items keep flowing in. Synchronous active-low reset
// empties the pipeline; star records are undefined until loaded.
module starfield_perspective_projector_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] star_index, [19:10] star_x, [29:20] star_y,
    // [44:30] star_depth, [53:45] star_speed, [55:54] zero
    input  logic [55:0] s_axis_tdata,
    // [0] op
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [9:0] pixel_x, [19:10] pixel_y, [41:20] pixel_address, [47:42] zero
    output logic [47:0] m_axis_tdata,
    // [0] visible
    output logic        m_axis_tuser
);

    localparam int QW = spp_pkg::QW;

    logic [spp_pkg::EYE_W-1:0]  r_eye;
    logic                       en;
    spp_pkg::t_item             item;
    spp_pkg::t_adv              adv;
    spp_pkg::t_tag              proj_tag;
    logic [spp_pkg::REM_W-1:0]  num_x, num_y;
    logic [spp_pkg::TWOD_W-1:0] twod;
    logic [QW-1:0]              q_x, q_y;
    spp_pkg::t_tag              r_tag [QW];
    logic                       r_out_valid;
    logic                       r_out_vis;
    logic [spp_pkg::PIX_W-1:0]  r_px, r_py;
    logic [spp_pkg::PADDR_W-1:0] r_paddr;
    logic [spp_pkg::PIX_W-1:0]  px, py;
    logic [35:0]                addr_full;

    // The whole pipeline advances unless a result sits unaccepted.
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        item.op         = spp_pkg::t_op'(s_axis_tuser);
        item.idx        = s_axis_tdata[9:0];
        item.star.x     = s_axis_tdata[19:10];
        item.star.y     = s_axis_tdata[29:20];
        item.star.depth = s_axis_tdata[44:30];
        item.star.speed = s_axis_tdata[53:45];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye <= spp_pkg::EYE_RESET;
        end else if (i_cfg_we) begin
            r_eye <= i_cfg_wdata;
        end
    end

    spp_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_item  (item),
        .o_adv   (adv)
    );

    spp_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_eye   (r_eye),
        .i_adv   (adv),
        .o_tag   (proj_tag),
        .o_num_x (num_x),
        .o_num_y (num_y),
        .o_twod  (twod)
    );

    spp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (num_x),
        .i_den (twod),
        .o_q   (q_x)
    );

    spp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (num_y),
        .i_den (twod),
        .o_q   (q_y)
    );

    // Valid and visible flags travel beside the divider stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QW; i++) begin
                r_tag[i] <= '0;
            end
        end else if (en) begin
            r_tag[0] <= proj_tag;
            for (int i = 1; i < QW; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    always_comb begin
        px        = spp_pkg::PIX_W'(q_x);
        py        = spp_pkg::PIX_W'(q_y);
        addr_full = (36'(q_x) + 36'(q_y) * 36'(spp_pkg::SCREEN_WIDTH)) << 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_tag[QW-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_vis <= r_tag[QW-1].vis;
            r_px      <= r_tag[QW-1].vis ? px : '0;
            r_py      <= r_tag[QW-1].vis ? py : '0;
            r_paddr   <= r_tag[QW-1].vis ? addr_full[spp_pkg::PADDR_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_vis;
    assign m_axis_tdata  = {6'b0, r_paddr, r_py, r_px};

    // An invisible star reports all-zero coordinates.
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invisible result with nonzero coordinates");

    // A visible pixel lies on the screen.
    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (int'(r_px) < spp_pkg::SCREEN_WIDTH && int'(r_py) < spp_pkg::SCREEN_HEIGHT))
        else $error("visible pixel off screen");

    // The byte address agrees with the reported column and row.
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (r_paddr == spp_pkg::PADDR_W'((36'(r_px)
                + 36'(r_py) * 36'(spp_pkg::SCREEN_WIDTH)) << 2)))
        else $error("pixel address mismatch");

endmodule

// ===== sv/spp_store.sv =====
module spp_store (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  spp_pkg::t_item i_item,
    output spp_pkg::t_adv  o_adv
);

    logic [$bits(spp_pkg::t_star)-1:0] mem [spp_pkg::NUM_STARS];

    spp_pkg::t_star              r_rd;
    logic                        r_b_valid;
    spp_pkg::t_item              r_b_item;
    logic                        r_fwd_valid;
    logic [spp_pkg::IDX_W-1:0]   r_fwd_idx;
    spp_pkg::t_star              r_fwd_data;
    spp_pkg::t_adv               r_adv;

    spp_pkg::t_star              rec;
    spp_pkg::t_star              wr_data;
    logic [spp_pkg::DEPTH_W:0]   diff;
    logic [spp_pkg::DEPTH_W-1:0] new_depth;
    logic                        in_range;
    logic                        wr_en;

    // The write of the previous item lands in the same cycle as this item's
    // read, so the read data may be stale; take the written record instead.
    always_comb begin
        rec = (r_fwd_valid && r_fwd_idx == r_b_item.idx) ? r_fwd_data : r_rd;
        diff = {1'b0, rec.depth} - (spp_pkg::DEPTH_W + 1)'(rec.speed);
        if (diff[spp_pkg::DEPTH_W] || diff == '0) begin
            new_depth = spp_pkg::DEPTH_RESET;
        end else begin
            new_depth = diff[spp_pkg::DEPTH_W-1:0];
        end
        in_range = int'(r_b_item.idx) < spp_pkg::NUM_STARS;
        if (r_b_item.op == spp_pkg::OP_LOAD) begin
            wr_data = r_b_item.star;
        end else begin
            wr_data       = rec;
            wr_data.depth = new_depth;
        end
        wr_en = i_en && r_b_valid && in_range;
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_rd <= mem[spp_pkg::ADDR_W'(i_item.idx)];
        end
        if (wr_en) begin
            mem[spp_pkg::ADDR_W'(r_b_item.idx)] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_adv.valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid   <= i_valid;
            r_fwd_valid <= r_b_valid && in_range;
            r_adv.valid <= r_b_valid && in_range && r_b_item.op == spp_pkg::OP_ADVANCE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_item    <= i_item;
            r_fwd_idx   <= r_b_item.idx;
            r_fwd_data  <= wr_data;
            r_adv.x     <= rec.x;
            r_adv.y     <= rec.y;
            r_adv.depth <= new_depth;
        end
    end

    assign o_adv = r_adv;

endmodule

// ===== sv/spp_proj.sv =====
module spp_proj (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [spp_pkg::EYE_W-1:0]    i_eye,
    input  spp_pkg::t_adv                i_adv,
    output spp_pkg::t_tag                o_tag,
    output logic [spp_pkg::REM_W-1:0]    o_num_x,
    output logic [spp_pkg::REM_W-1:0]    o_num_y,
    output logic [spp_pkg::TWOD_W-1:0]   o_twod
);

    logic [spp_pkg::DEN_W-1:0]         den;
    logic signed [spp_pkg::NUM_W-1:0]  cx, cy, nx, ny, lim_x, lim_y;
    logic signed [spp_pkg::NUM_W-1:0]  r_nx, r_ny;
    logic [spp_pkg::TWOD_W-1:0]        r_twod1, r_twod2;
    logic                              r_v1;
    spp_pkg::t_tag                     r_tag;
    logic [spp_pkg::REM_W-1:0]         r_rx, r_ry;
    logic                              vx, vy;

    // Numerator of s = N / 2D: N = size*D + 256*E*(2c - size).
    always_comb begin
        den = spp_pkg::DEN_W'({i_eye, 8'b0}) + spp_pkg::DEN_W'(i_adv.depth);
        cx  = $signed(spp_pkg::NUM_W'({i_adv.x, 1'b0}))
            - $signed(spp_pkg::NUM_W'(spp_pkg::SCREEN_WIDTH));
        cy  = $signed(spp_pkg::NUM_W'({i_adv.y, 1'b0}))
            - $signed(spp_pkg::NUM_W'(spp_pkg::SCREEN_HEIGHT));
        nx  = $signed(spp_pkg::NUM_W'(spp_pkg::SCREEN_WIDTH) * spp_pkg::NUM_W'(den))
            + (($signed(spp_pkg::NUM_W'(i_eye)) * cx) <<< 8);
        ny  = $signed(spp_pkg::NUM_W'(spp_pkg::SCREEN_HEIGHT) * spp_pkg::NUM_W'(den))
            + (($signed(spp_pkg::NUM_W'(i_eye)) * cy) <<< 8);
        lim_x = $signed(spp_pkg::NUM_W'(spp_pkg::SCREEN_WIDTH) * spp_pkg::NUM_W'(r_twod1));
        lim_y = $signed(spp_pkg::NUM_W'(spp_pkg::SCREEN_HEIGHT) * spp_pkg::NUM_W'(r_twod1));
        vx  = (r_nx > 0) && (r_nx < lim_x);
        vy  = (r_ny > 0) && (r_ny < lim_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_v1        <= i_adv.valid;
            r_tag.valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx      <= nx;
            r_ny      <= ny;
            r_twod1   <= {den, 1'b0};
            r_tag.vis <= vx && vy;
            r_rx      <= spp_pkg::REM_W'(r_nx);
            r_ry      <= spp_pkg::REM_W'(r_ny);
            r_twod2   <= r_twod1;
        end
    end

    assign o_tag   = r_tag;
    assign o_num_x = r_rx;
    assign o_num_y = r_ry;
    assign o_twod  = r_twod2;

endmodule

// ===== sv/spp_div.sv =====
module spp_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [spp_pkg::REM_W-1:0]   i_num,
    input  logic [spp_pkg::TWOD_W-1:0]  i_den,
    output logic [spp_pkg::QW-1:0]      o_q
);

    localparam int QW = spp_pkg::QW;
    localparam int RW = spp_pkg::REM_W;

    logic [RW-1:0]                 r_rem [QW];
    logic [spp_pkg::TWOD_W-1:0]    r_den [QW];
    logic [QW-1:0]                 r_q   [QW];

    // One quotient bit per stage, most significant first.
    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [RW-1:0]              rem_in;
        logic [spp_pkg::TWOD_W-1:0] den_in;
        logic [QW-1:0]              q_in;
        logic [RW+QW-1:0]           sub;

        if (i == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign den_in = r_den[i-1];
            assign q_in   = r_q[i-1];
        end

        assign sub = (RW + QW)'(den_in) << (QW - 1 - i);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[i] <= den_in;
                if ({{QW{1'b0}}, rem_in} >= sub) begin
                    r_rem[i] <= rem_in - RW'(sub);
                    r_q[i]   <= q_in | (QW'(1) << (QW - 1 - i));
                end else begin
                    r_rem[i] <= rem_in;
                    r_q[i]   <= q_in;
                end
            end
        end
    end

    assign o_q = r_q[QW-1];

endmodule
